[rtl/core/raar_pkg.sv]
// Shared types and constants for the register access responder.
package raar_pkg;

    // Received mode codes
    localparam logic [2:0] MODE_REPLY_ACK = 3'd1;
    localparam logic [2:0] MODE_READ      = 3'd2;
    localparam logic [2:0] MODE_WRITE     = 3'd3;

    // Result kind codes
    localparam logic [2:0] KIND_REQ_ACK = 3'd0;
    localparam logic [2:0] KIND_ERROR   = 3'd1;
    localparam logic [2:0] KIND_DATA    = 3'd2;
    localparam logic [2:0] KIND_RESEND  = 3'd3;
    localparam logic [2:0] KIND_WRITE   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_VALID_BASE  = 2'd0;
    localparam logic [1:0] REG_VALID_LIMIT = 2'd1;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;

    // Resend counter saturates here
    localparam logic [3:0] CNT_MAX = 4'hF;

    // Command class decided by the front part
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_ACK,
        CLS_READ,
        CLS_WRITE,
        CLS_ERROR
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [7:0]  id;
        logic [31:0] addr;
        logic [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  id;
        logic [31:0] addr;
        logic [31:0] value;
    } result_t;

    typedef struct packed {
        logic [3:0]  resends;
        logic [7:0]  id;
        logic [31:0] addr;
        logic [31:0] value;
    } entry_t;

    typedef struct packed {
        logic [31:0] valid_base;
        logic [31:0] valid_limit;
        logic [3:0]  retry_limit;
    } cfg_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ACT,
        B_DATA,
        B_ACK2,
        B_SWEEP,
        B_FIN
    } back_state_t;

endpackage

[rtl/core/raar_front.sv]
// Front part: accepts received items and classifies them into commands.
module raar_front
    import raar_pkg::*;
(
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [2:0]  mode,
    input  logic [7:0]  pack_id,
    input  logic [31:0] reg_addr,
    input  logic [31:0] write_value,
    input  logic [31:0] read_value,
    input  cfg_t        cfg,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_data
);

    logic in_window;

    // Hold off the sender while the queue is full
    assign cmd_stall = q_full;
    assign q_push    = cmd_valid && !q_full;

    assign in_window = (reg_addr >= cfg.valid_base) && (reg_addr <= cfg.valid_limit);

    // Classify the item and pick the value it carries
    always_comb
    begin
        q_data.id    = pack_id;
        q_data.addr  = reg_addr;
        q_data.value = read_value;
        case (mode)
            MODE_REPLY_ACK: q_data.cls = CLS_ACK;
            MODE_READ:      q_data.cls = CLS_READ;
            MODE_WRITE:
            begin
                q_data.cls   = in_window ? CLS_WRITE : CLS_ERROR;
                q_data.value = write_value;
            end
            default:        q_data.cls = CLS_NONE;
        endcase
    end

endmodule

[rtl/core/raar_queue.sv]
// Two-entry command queue between the front and back parts.
module raar_queue
    import raar_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/raar_back.sv]
// Back part: carries out commands, owns the retransmit table, emits results.
module raar_back
    import raar_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_empty,
    input  cmd_t        q_data,
    output logic        q_pop,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  kind,
    output logic [7:0]  out_id,
    output logic [31:0] out_addr,
    output logic [31:0] out_value,
    output logic        last
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    back_state_t state_reg;
    back_state_t state_next;

    cmd_t                 cmd_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [TABLE_ENTRIES-1:0] waiting_reg;
    logic                 hold_valid_reg;
    logic                 hold_valid_next;
    result_t              hold_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_t              out_reg;
    logic                 out_last_reg;

    // Table memory and its registered read port
    entry_t               table_mem [TABLE_ENTRIES];
    entry_t               rd_q;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    entry_t               mem_wdata;

    logic                 can_push;
    logic                 res_req;
    result_t              res_new;
    logic                 step_ok;
    logic                 fin_push;
    logic                 push_out;
    logic                 wait_set;
    logic                 wait_clr;
    logic [IDX_W-1:0]     wait_idx;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;

    assign can_push = !out_valid_reg || !rsp_stall;
    assign step_ok  = !res_req || !hold_valid_reg || can_push;

    // Find the lowest free table entry
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!waiting_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_ACT;
                end
            end
            B_ACT:
            begin
                case (cmd_reg.cls)
                    CLS_READ:  state_next = B_DATA;
                    CLS_WRITE: state_next = B_ACK2;
                    default:   state_next = B_SWEEP;
                endcase
            end
            B_DATA, B_ACK2:
            begin
                if (step_ok)
                begin
                    state_next = B_SWEEP;
                end
            end
            B_SWEEP:
            begin
                if (step_ok && (idx_reg == LAST_IDX))
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                if (!hold_valid_reg || can_push)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Per-state actions: results, table writes, waiting bit changes
    always_comb
    begin
        q_pop     = 1'b0;
        res_req   = 1'b0;
        res_new   = '0;
        fin_push  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = rd_q;
        wait_set  = 1'b0;
        wait_clr  = 1'b0;
        wait_idx  = idx_reg;
        rd_addr   = '0;
        case (state_reg)
            B_IDLE:
            begin
                q_pop = !q_empty;
            end
            B_ACT:
            begin
                res_new.id = cmd_reg.id;
                case (cmd_reg.cls)
                    CLS_READ:
                    begin
                        res_req      = 1'b1;
                        res_new.kind = KIND_REQ_ACK;
                        // Park the data frame in the first free entry
                        if (free_found)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = free_idx;
                            mem_wdata = '{resends: '0, id: cmd_reg.id,
                                          addr: cmd_reg.addr, value: cmd_reg.value};
                            wait_set  = 1'b1;
                            wait_idx  = free_idx;
                        end
                    end
                    CLS_WRITE:
                    begin
                        res_req       = 1'b1;
                        res_new.kind  = KIND_WRITE;
                        res_new.addr  = cmd_reg.addr;
                        res_new.value = cmd_reg.value;
                    end
                    CLS_ERROR:
                    begin
                        res_req      = 1'b1;
                        res_new.kind = KIND_ERROR;
                    end
                    default:
                    begin
                        res_req = 1'b0;
                    end
                endcase
            end
            B_DATA:
            begin
                res_req       = 1'b1;
                res_new.kind  = KIND_DATA;
                res_new.id    = cmd_reg.id;
                res_new.addr  = cmd_reg.addr;
                res_new.value = cmd_reg.value;
            end
            B_ACK2:
            begin
                res_req      = 1'b1;
                res_new.kind = KIND_REQ_ACK;
                res_new.id   = cmd_reg.id;
            end
            B_SWEEP:
            begin
                res_new = '{kind: KIND_RESEND, id: rd_q.id, addr: rd_q.addr,
                            value: rd_q.value};
                if (waiting_reg[idx_reg])
                begin
                    if ((cmd_reg.cls == CLS_ACK) && (rd_q.id == cmd_reg.id))
                    begin
                        // Drop entries matched by a reply acknowledgment
                        wait_clr = 1'b1;
                    end
                    else if (rd_q.resends == '0)
                    begin
                        // Freshly stored: arm it, send nothing
                        mem_we            = 1'b1;
                        mem_wdata.resends = 4'd1;
                    end
                    else if (rd_q.resends > cfg.retry_limit)
                    begin
                        wait_clr = 1'b1;
                    end
                    else
                    begin
                        res_req           = 1'b1;
                        mem_we            = step_ok;
                        mem_wdata.resends = (rd_q.resends < CNT_MAX) ?
                                            rd_q.resends + 4'd1 : rd_q.resends;
                    end
                end
                // Read ahead to the next entry once this one is done
                if (!step_ok)
                begin
                    rd_addr = idx_reg;
                end
                else if (idx_reg != LAST_IDX)
                begin
                    rd_addr = idx_reg + IDX_W'(1);
                end
            end
            B_FIN:
            begin
                fin_push = hold_valid_reg && can_push;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Hold the newest result until the next one shows whether it is the last
    always_comb
    begin
        push_out        = (res_req && hold_valid_reg && can_push) || fin_push;
        hold_valid_next = hold_valid_reg;
        if (res_req && step_ok)
        begin
            hold_valid_next = 1'b1;
        end
        else if (fin_push)
        begin
            hold_valid_next = 1'b0;
        end
        out_valid_next = push_out ? 1'b1 : (out_valid_reg && rsp_stall);
        idx_next       = idx_reg;
        if ((state_reg == B_SWEEP) && step_ok)
        begin
            idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            idx_reg        <= '0;
            waiting_reg    <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (wait_set)
            begin
                waiting_reg[wait_idx] <= 1'b1;
            end
            else if (wait_clr)
            begin
                waiting_reg[wait_idx] <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_data;
        end
        if (res_req && step_ok)
        begin
            hold_reg <= res_new;
        end
        if (push_out)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= fin_push;
        end
    end

    // Table memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_q <= table_mem[rd_addr];
    end

    assign rsp_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign out_id    = out_reg.id;
    assign out_addr  = out_reg.addr;
    assign out_value = out_reg.value;
    assign last      = out_last_reg;

endmodule

[rtl/core/register_access_ack_retransmit.sv]
// Each result is held until the next one shows whether it is the last. The retransmit sweep
// reads one table entry per cycle while the output is not stalled; a two-entry queue lets the
// front take items while the back sweeps. Reset clears control state and all waiting flags and
// returns the configuration to its defaults; table contents stay undefined and need no
// clearing pass.
module register_access_ack_retransmit
    import raar_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [2:0]  mode,
    input  logic [7:0]  pack_id,
    input  logic [31:0] reg_addr,
    input  logic [31:0] write_value,
    input  logic [31:0] read_value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  kind,
    output logic [7:0]  out_id,
    output logic [31:0] out_addr,
    output logic [31:0] out_value,
    output logic        last
);

    cfg_t cfg_reg;
    logic wr_en;
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_in;
    cmd_t q_out;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.valid_base  <= 32'h0000_0000;
            cfg_reg.valid_limit <= 32'hFFFF_FFFF;
            cfg_reg.retry_limit <= 4'd3;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_VALID_BASE:  cfg_reg.valid_base  <= pwdata;
                REG_VALID_LIMIT: cfg_reg.valid_limit <= pwdata;
                REG_RETRY_LIMIT: cfg_reg.retry_limit <= pwdata[3:0];
                default:         cfg_reg.retry_limit <= cfg_reg.retry_limit;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        case (paddr[3:2])
            REG_VALID_BASE:  prdata = cfg_reg.valid_base;
            REG_VALID_LIMIT: prdata = cfg_reg.valid_limit;
            REG_RETRY_LIMIT: prdata = {28'd0, cfg_reg.retry_limit};
            default:         prdata = 32'd0;
        endcase
    end

    raar_front u_front (
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .mode        (mode),
        .pack_id     (pack_id),
        .reg_addr    (reg_addr),
        .write_value (write_value),
        .read_value  (read_value),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    raar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    raar_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .kind      (kind),
        .out_id    (out_id),
        .out_addr  (out_addr),
        .out_value (out_value),
        .last      (last)
    );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the register access responder with ack retransmit.
module tb_top
    import raar_pkg::*;
();

    localparam int ENTRIES = 8;
    localparam int DRAIN_CYCLES = 4 * (ENTRIES + 4) + 16;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PER_PHASE = 27;

    // Modes that the package leaves unnamed
    localparam logic [2:0] MODE_TIMEOUT     = 3'd0;
    localparam logic [2:0] MODE_UNKNOWN     = 3'd4;
    localparam logic [2:0] MODE_UNKNOWN_MAX = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  id;
        logic [31:0] addr;
        logic [31:0] value;
        logic        last;
    } frame_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        cmd_valid   = 1'b0;
    logic        cmd_stall;
    logic [2:0]  mode        = MODE_TIMEOUT;
    logic [7:0]  pack_id     = '0;
    logic [31:0] reg_addr    = '0;
    logic [31:0] write_value = '0;
    logic [31:0] read_value  = '0;
    logic        rsp_valid;
    logic        rsp_stall   = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  out_id;
    logic [31:0] out_addr;
    logic [31:0] out_value;
    logic        last;

    // Expected frames, oldest first
    frame_t frames_due[$];
    int     mismatches = 0;

    // Idle controls for the sender and the receiver, and the watchdog's idle count
    int send_idle_pct = 0;
    int stall_pct = 0;
    int holdoff_seq = 0;
    int holdoff_seen = 0;
    int holdoff_left = 0;
    int idle_cycles = 0;

    // Mirror of the configuration and the retransmit table
    logic [31:0] win_base = 32'h0;
    logic [31:0] win_limit = 32'hFFFF_FFFF;
    logic [3:0]  max_retry = 4'd3;
    bit          tbl_wait [ENTRIES];
    logic [3:0]  tbl_cnt [ENTRIES];
    logic [7:0]  tbl_id [ENTRIES];
    logic [31:0] tbl_addr [ENTRIES];
    logic [31:0] tbl_val [ENTRIES];

    register_access_ack_retransmit #(.TABLE_ENTRIES(ENTRIES)) dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .mode(mode), .pack_id(pack_id), .reg_addr(reg_addr),
        .write_value(write_value), .read_value(read_value),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .kind(kind), .out_id(out_id), .out_addr(out_addr),
        .out_value(out_value), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic frame_t make_frame(logic [2:0] k, logic [7:0] id,
                                          logic [31:0] a, logic [31:0] v);
        frame_t f;
        f.kind = k;
        f.id = id;
        f.addr = a;
        f.value = v;
        f.last = 1'b0;
        return f;
    endfunction

    // Work out the frames one command causes and update the table mirror
    task automatic compute_frames(input logic [2:0] m, input logic [7:0] id,
                                  input logic [31:0] a, input logic [31:0] wv,
                                  input logic [31:0] rv);
        frame_t out_q[$];
        frame_t f;
        bit     stored;
        stored = 1'b0;
        case (m)
            MODE_REPLY_ACK:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_wait[i] && tbl_id[i] == id)
                        tbl_wait[i] = 1'b0;
            end
            MODE_READ:
            begin
                out_q.push_back(make_frame(KIND_REQ_ACK, id, '0, '0));
                out_q.push_back(make_frame(KIND_DATA, id, a, rv));
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!stored && !tbl_wait[i])
                    begin
                        tbl_wait[i] = 1'b1;
                        tbl_cnt[i] = 4'd0;
                        tbl_id[i] = id;
                        tbl_addr[i] = a;
                        tbl_val[i] = rv;
                        stored = 1'b1;
                    end
                end
            end
            MODE_WRITE:
            begin
                if (a >= win_base && a <= win_limit)
                begin
                    out_q.push_back(make_frame(KIND_WRITE, id, a, wv));
                    out_q.push_back(make_frame(KIND_REQ_ACK, id, '0, '0));
                end
                else
                    out_q.push_back(make_frame(KIND_ERROR, id, '0, '0));
            end
            default:
            begin
            end
        endcase
        // Sweep the table: arm fresh entries, retire stale ones, resend the rest
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_wait[i])
            begin
                if (tbl_cnt[i] == 4'd0)
                    tbl_cnt[i] = 4'd1;
                else if (tbl_cnt[i] > max_retry)
                    tbl_wait[i] = 1'b0;
                else
                begin
                    out_q.push_back(make_frame(KIND_RESEND, tbl_id[i], tbl_addr[i],
                                               tbl_val[i]));
                    if (tbl_cnt[i] != CNT_MAX)
                        tbl_cnt[i] = tbl_cnt[i] + 4'd1;
                end
            end
        end
        if (out_q.size() > 0)
        begin
            f = out_q[out_q.size() - 1];
            f.last = 1'b1;
            out_q[out_q.size() - 1] = f;
        end
        foreach (out_q[i])
            frames_due.push_back(out_q[i]);
    endtask

    // Offer one item after a random gap and hold it until accepted
    task automatic send_cmd(input logic [2:0] m, input logic [7:0] id,
                            input logic [31:0] a, input logic [31:0] wv,
                            input logic [31:0] rv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        mode <= m;
        pack_id <= id;
        reg_addr <= a;
        write_value <= wv;
        read_value <= rv;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        compute_frames(m, id, a, wv, rv);
    endtask

    // Drop valid, wait for every expected frame, then let the pipe settle
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] base, input logic [31:0] limit,
                              input logic [3:0] retry);
        wait_idle();
        apb_write(REG_VALID_BASE, base);
        apb_write(REG_VALID_LIMIT, limit);
        apb_write(REG_RETRY_LIMIT, {28'h0, retry});
        win_base = base;
        win_limit = limit;
        max_retry = retry;
    endtask

    // Pick a write address near or inside the window, edges included, or a random one
    function automatic logic [31:0] pick_write_addr();
        longint unsigned span;
        case ($urandom_range(5))
            0: return win_base;
            1: return win_limit;
            2: return win_base - 32'd1;
            3: return win_limit + 32'd1;
            4:
            begin
                if (win_base > win_limit)
                    return $urandom;
                span = longint'(win_limit) - longint'(win_base) + 1;
                return win_base + 32'(longint'($urandom) % span);
            end
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed traffic: reads, acks for live ids, writes near the window
    task automatic random_cmd();
        logic [7:0] live_ids[$];
        logic [2:0] m;
        logic [7:0] id;
        logic [31:0] a;
        int r;
        r = $urandom_range(99);
        id = ($urandom_range(2) == 0) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
        a = $urandom;
        if (r < 35)
            m = MODE_READ;
        else if (r < 55)
        begin
            m = MODE_REPLY_ACK;
            for (int i = 0; i < ENTRIES; i++)
                if (tbl_wait[i])
                    live_ids.push_back(tbl_id[i]);
            if (live_ids.size() > 0 && $urandom_range(9) < 7)
                id = live_ids[$urandom_range(live_ids.size() - 1)];
        end
        else if (r < 80)
        begin
            m = MODE_WRITE;
            a = pick_write_addr();
        end
        else if (r < 90)
            m = MODE_TIMEOUT;
        else
            m = 3'($urandom_range(int'(MODE_UNKNOWN_MAX), int'(MODE_UNKNOWN)));
        send_cmd(m, id, a, $urandom, $urandom);
    endtask

    // Window edges, full window and an empty window
    task automatic test_write_window();
        set_config(32'h0, 32'hFFFF_FFFF, 4'd3);
        send_cmd(MODE_WRITE, 8'h00, 32'h0, 32'h0, 32'h0);
        send_cmd(MODE_WRITE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_config(32'h100, 32'h1FF, 4'd3);
        send_cmd(MODE_WRITE, 8'h11, 32'hFF, 32'h1234_5678, 32'h0);
        send_cmd(MODE_WRITE, 8'h12, 32'h100, 32'hA5A5_A5A5, 32'h0);
        send_cmd(MODE_WRITE, 8'h13, 32'h1FF, 32'h5A5A_5A5A, 32'h0);
        send_cmd(MODE_WRITE, 8'h14, 32'h200, 32'hFFFF_FFFF, 32'h0);
        set_config(32'h5, 32'h4, 4'd3);
        send_cmd(MODE_WRITE, 8'h15, 32'h5, 32'h1, 32'h0);
    endtask

    // Resends until the retry limit, a reply ack and unknown modes
    task automatic test_read_retransmit();
        set_config(32'h0, 32'hFFFF_FFFF, 4'd3);
        send_cmd(MODE_READ, 8'h00, 32'h0, 32'h0, 32'h0);
        send_cmd(MODE_READ, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (3) send_cmd(MODE_TIMEOUT, 8'h00, 32'h0, 32'h0, 32'h0);
        send_cmd(MODE_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(MODE_REPLY_ACK, 8'hFF, 32'h0, 32'h0, 32'h0);
        send_cmd(MODE_UNKNOWN_MAX, 8'h00, 32'h0, 32'h0, 32'h0);
    endtask

    // Fill the table past capacity, clear duplicates by one ack, then retire all
    task automatic test_table_full();
        set_config(32'h0, 32'hFFFF_FFFF, 4'd15);
        send_cmd(MODE_READ, 8'h03, 32'h30, 32'hDEAD_0000, 32'hC0DE_0003);
        for (int i = 3; i <= 10; i++)
            send_cmd(MODE_READ, 8'(i), 32'(i << 4), 32'h0, 32'hC0DE_0000 | 32'(i));
        send_cmd(MODE_REPLY_ACK, 8'h03, 32'h0, 32'h0, 32'h0);
        set_config(32'h0, 32'hFFFF_FFFF, 4'd0);
        send_cmd(MODE_TIMEOUT, 8'h00, 32'h0, 32'h0, 32'h0);
    endtask

    // Hold the receiver off while items keep coming, then pause until drained
    task automatic test_backpressure();
        set_config(32'h0, 32'h7FFF_FFFF, 4'd2);
        send_idle_pct = 0;
        stall_pct = 0;
        holdoff_seq++;
        repeat (10) random_cmd();
        wait_idle();
        repeat (5) random_cmd();
    endtask

    task automatic test_random_phase(input int sidle, input int rstall,
                                     input logic [31:0] base, input logic [31:0] limit,
                                     input logic [3:0] retry);
        set_config(base, limit, retry);
        send_idle_pct = sidle;
        stall_pct = rstall;
        repeat (RANDOM_PER_PHASE) random_cmd();
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (holdoff_seen != holdoff_seq)
        begin
            holdoff_seen = holdoff_seq;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic void check_field(input string field, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Compare each accepted frame with the oldest expectation
    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (frames_due.size() == 0)
            begin
                $display("%0t: unexpected frame, expected none, actual kind %0d id 0x%0h",
                         $time, kind, out_id);
                mismatches++;
            end
            else
            begin
                want = frames_due.pop_front();
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("out_id", 32'(want.id), 32'(out_id));
                check_field("out_addr", want.addr, out_addr);
                check_field("out_value", want.value, out_value);
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || psel)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[register_access_ack_retransmit] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
            tbl_wait[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_write_window();
        test_read_retransmit();
        test_table_full();
        test_backpressure();
        test_random_phase(0, 0, 32'h0, 32'hFFFF_FFFF, 4'd3);
        test_random_phase(67, 0, $urandom, $urandom, 4'($urandom_range(15)));
        test_random_phase(0, 67, $urandom, $urandom, 4'd15);
        test_random_phase(24, 24, 32'h8000_0000, 32'hFFFF_FFFF, 4'($urandom_range(15)));

        send_idle_pct = 0;
        stall_pct = 0;
        wait_idle();
        if (mismatches == 0)
            $display("[register_access_ack_retransmit] OK");
        else
            $display("[register_access_ack_retransmit] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/core/raar_pkg.sv
rtl/core/raar_front.sv
rtl/core/raar_queue.sv
rtl/core/raar_back.sv
rtl/core/register_access_ack_retransmit.sv
tb/tb_top.sv
